### rtl/core/bkct_pkg.sv
package bkct_pkg;

  localparam int TagW        = 24;
  localparam int ChkW        = 32;
  localparam int KeyW        = 32;
  localparam int BucketW     = 8;
  localparam int BucketCount = 256;
  localparam int BucketShift = 24;
  localparam int EntryW      = TagW + ChkW;

  typedef enum logic {
    ActInsert = 1'b0,
    ActLookup = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StatInserted  = 2'd0,
    StatDuplicate = 2'd1,
    StatFull      = 2'd2,
    StatLookup    = 2'd3
  } status_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StCheck = 1'b1
  } state_e;

  typedef struct packed {
    logic            hit;
    logic            full;
    logic [ChkW-1:0] checksum;
  } match_t;

endpackage

### rtl/core/bkct_ram.sv
module bkct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bkct_match.sv
module bkct_match #(
  parameter int BUCKET_WAYS = 4
) (
  input  logic [BUCKET_WAYS*bkct_pkg::EntryW-1:0] entries_i,
  input  logic [$clog2(BUCKET_WAYS+1)-1:0]        fill_i,
  input  logic [bkct_pkg::TagW-1:0]               tag_i,
  output bkct_pkg::match_t                        match_o
);

  localparam int FillW  = $clog2(BUCKET_WAYS+1);
  localparam int EntryW = bkct_pkg::EntryW;
  localparam int TagW   = bkct_pkg::TagW;
  localparam int ChkW   = bkct_pkg::ChkW;

  logic [BUCKET_WAYS-1:0] way_hit;

  // only filled ways take part; unwritten ways are never compared
  always_comb begin
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      way_hit[w] = (FillW'(w) < fill_i) &&
                   (entries_i[w*EntryW +: TagW] == tag_i);
    end
  end

  always_comb begin
    match_o.hit      = 1'b0;
    match_o.checksum = '0;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (way_hit[w]) begin
        match_o.hit      = 1'b1;
        match_o.checksum = entries_i[w*EntryW + TagW +: ChkW];
      end
    end
    match_o.full = (fill_i >= FillW'(BUCKET_WAYS));
  end

endmodule

### rtl/core/bucketed_key_checksum_table_core.sv
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+---------------------------
// request   | action_i, file_key_i, checksum_in_i            | start & !busy
// result    | found_o, checksum_out_o, status_o              | result_valid_o, 1 cycle
//
// The bucket row of a request is read from the row RAM in the accept cycle,
// then compared, and written back for a new insert with room, in the next; busy is high then.
// The result strobe is registered from the check state; the next request may start as it shows.
// Reset clears the per-bucket valid bits, so every bucket reads as empty; no
// clearing pass is needed. The result receiver cannot stall the block.
module bucketed_key_checksum_table_core #(
  parameter int BUCKET_WAYS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [bkct_pkg::KeyW-1:0]    file_key_i,
  input  logic [bkct_pkg::ChkW-1:0]    checksum_in_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [bkct_pkg::ChkW-1:0]    checksum_out_o,
  output logic [1:0]                   status_o
);

  localparam int FillW   = $clog2(BUCKET_WAYS+1);
  localparam int EntryW  = bkct_pkg::EntryW;
  localparam int TagW    = bkct_pkg::TagW;
  localparam int ChkW    = bkct_pkg::ChkW;
  localparam int BucketW = bkct_pkg::BucketW;
  localparam int SlotsW  = BUCKET_WAYS * EntryW;
  localparam int RowW    = SlotsW + FillW;

  bkct_pkg::state_e state_q, state_d;

  logic                 accept;
  logic                 action_q;
  logic [TagW-1:0]      tag_q;
  logic [ChkW-1:0]      chk_q;
  logic [BucketW-1:0]   bucket_q;

  logic [bkct_pkg::BucketCount-1:0] row_valid_q;

  logic [RowW-1:0]      rd_row;
  logic [RowW-1:0]      wr_row;
  logic [FillW-1:0]     fill_cur;
  logic                 row_we;
  bkct_pkg::match_t     match;

  logic                 result_valid_q;
  logic                 found_q;
  logic [ChkW-1:0]      checksum_q;
  bkct_pkg::status_e    status_q;
  bkct_pkg::status_e    status_d;

  assign busy   = (state_q != bkct_pkg::StIdle);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bkct_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    row_we  = 1'b0;
    unique case (state_q)
      bkct_pkg::StIdle: begin
        if (accept) begin
          state_d = bkct_pkg::StCheck;
        end
      end
      bkct_pkg::StCheck: begin
        state_d = bkct_pkg::StIdle;
        row_we  = (action_q == bkct_pkg::ActInsert) && !match.hit && !match.full;
      end
      default: state_d = bkct_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      tag_q    <= file_key_i[TagW-1:0];
      chk_q    <= checksum_in_i;
      bucket_q <= file_key_i[bkct_pkg::BucketShift +: BucketW];
    end
  end

  bkct_ram #(
    .WIDTH (RowW),
    .DEPTH (bkct_pkg::BucketCount)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (bucket_q),
    .wdata_i (wr_row),
    .re_i    (accept),
    .raddr_i (file_key_i[bkct_pkg::BucketShift +: BucketW]),
    .rdata_o (rd_row)
  );

  // a bucket never written reads as empty
  assign fill_cur = row_valid_q[bucket_q] ? rd_row[RowW-1 -: FillW] : '0;

  bkct_match #(
    .BUCKET_WAYS (BUCKET_WAYS)
  ) u_match (
    .entries_i (rd_row[SlotsW-1:0]),
    .fill_i    (fill_cur),
    .tag_i     (tag_q),
    .match_o   (match)
  );

  // append the new entry at the first free way and bump the fill count
  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (FillW'(w) == fill_cur) begin
        wr_row[w*EntryW +: EntryW] = {chk_q, tag_q};
      end
    end
    wr_row[RowW-1 -: FillW] = fill_cur + FillW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (row_we) begin
      row_valid_q[bucket_q] <= 1'b1;
    end
  end

  always_comb begin
    priority if (action_q == bkct_pkg::ActLookup) begin
      status_d = bkct_pkg::StatLookup;
    end else if (match.hit) begin
      status_d = bkct_pkg::StatDuplicate;
    end else if (match.full) begin
      status_d = bkct_pkg::StatFull;
    end else begin
      status_d = bkct_pkg::StatInserted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= (state_q == bkct_pkg::StCheck);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bkct_pkg::StCheck) begin
      found_q    <= match.hit;
      checksum_q <= (action_q == bkct_pkg::ActLookup && match.hit) ? match.checksum : '0;
      status_q   <= status_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign found_o        = found_q;
  assign checksum_out_o = checksum_q;
  assign status_o       = status_q;

endmodule
